/* rtl/midpoint_ellipse_rasterizer_assert.svh */
// Assertion macros used by the midpoint ellipse rasterizer controller.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MER_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mer: next-cycle check failed");

`endif

/* rtl/mer_pkg.sv */
// Shared types and codes for the midpoint ellipse rasterizer.
package mer_pkg;

   // Request opcode: start a new ellipse (any other value advances one step)
   localparam logic OPC_START = 1'b0;

   // Datapath operation for one cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_RX,
      OP_MUL_RY,
      OP_MUL_GRAD,
      OP_START_Q,
      OP_MUL_TX,
      OP_MUL_YM,
      OP_MUL_RY2SQ,
      OP_MUL_RX2D,
      OP_R2_Q,
      OP_ROUND,
      OP_STEP_A,
      OP_STEP_B
   } op_type;

   // Kind of result beat to build
   typedef enum logic [1:0] {
      OUT_START,
      OUT_NONE,
      OUT_POINTS
   } out_kind_type;

   typedef struct packed {
      op_type       op;
      logic         region_two;
      out_kind_type out_kind;
      logic         out_load;
   } mer_cmd_type;

   typedef struct packed {
      logic r1_go;   // grad_x < grad_y: still in region one
      logic y_zero;  // offset_y has reached zero
   } mer_status_type;

endpackage

/* rtl/mer_if.sv */
// Request and response channel interfaces of the midpoint ellipse rasterizer.
interface mer_req_if #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic signed [COORD_BITS-1:0] centre_x;
   logic signed [COORD_BITS-1:0] centre_y;
   logic [RADIUS_BITS-1:0]       radius_x;
   logic [RADIUS_BITS-1:0]       radius_y;

   modport source (output valid, opcode, centre_x, centre_y, radius_x, radius_y,
                   input ready);
   modport sink (input valid, opcode, centre_x, centre_y, radius_x, radius_y,
                 output ready);
endinterface

interface mer_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                       valid;
   logic                       ready;
   logic                       points_valid;
   logic                       finished;
   logic signed [COORD_BITS:0] east_x;
   logic signed [COORD_BITS:0] west_x;
   logic signed [COORD_BITS:0] north_y;
   logic signed [COORD_BITS:0] south_y;

   modport source (output valid, points_valid, finished, east_x, west_x, north_y, south_y,
                   input ready);
   modport sink (input valid, points_valid, finished, east_x, west_x, north_y, south_y,
                 output ready);
endinterface

/* rtl/midpoint_ellipse_rasterizer.sv */
// One beat at a time: the next beat is taken the cycle after the result is registered, and
// a plain step runs its state update through ST_STEP_A and then ST_STEP_B.
// The region switch and start setup run their products through one shared multiplier.
// Reset is synchronous, active high: controller goes idle, no result is pending,
// datapath registers are not cleared and a step before any start reports finished.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
) (
   input logic       clock,
   input logic       reset,
   mer_req_if.sink   req_chan,
   mer_rsp_if.source rsp_chan
);

   mer_cmd_type    cmd;
   mer_status_type status;

   // Sequencer
   mer_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   // Arithmetic and result register
   mer_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_centre_x     (req_chan.centre_x),
      .req_centre_y     (req_chan.centre_y),
      .req_radius_x     (req_chan.radius_x),
      .req_radius_y     (req_chan.radius_y),
      .rsp_points_valid (rsp_chan.points_valid),
      .rsp_finished     (rsp_chan.finished),
      .rsp_east_x       (rsp_chan.east_x),
      .rsp_west_x       (rsp_chan.west_x),
      .rsp_north_y      (rsp_chan.north_y),
      .rsp_south_y      (rsp_chan.south_y)
   );

endmodule

/* rtl/mer_datapath.sv */
// Datapath: shared multiplier, decision/gradient registers and result register.
module mer_datapath import mer_pkg::*; #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
) (
   input  logic                         clock,
   input  mer_cmd_type                  cmd,
   output mer_status_type               status,
   input  logic signed [COORD_BITS-1:0] req_centre_x,
   input  logic signed [COORD_BITS-1:0] req_centre_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   output logic                         rsp_points_valid,
   output logic                         rsp_finished,
   output logic signed [COORD_BITS:0]   rsp_east_x,
   output logic signed [COORD_BITS:0]   rsp_west_x,
   output logic signed [COORD_BITS:0]   rsp_north_y,
   output logic signed [COORD_BITS:0]   rsp_south_y
);

   localparam int XW = RADIUS_BITS + 1;          // offset_x
   localparam int YW = RADIUS_BITS + 1;          // offset_y - 1, signed
   localparam int SW = 2 * RADIUS_BITS;          // squared radii
   localparam int GW = 3 * RADIUS_BITS + 3;      // gradients
   localparam int AW = 2 * RADIUS_BITS + 1;      // multiplier operand a
   localparam int BW = 2 * RADIUS_BITS + 5;      // multiplier operand b
   localparam int QW = AW + BW;                  // products, quarter values, decision
   localparam int OW = COORD_BITS + 1;           // output coordinates
   localparam int EW = ((OW > XW) ? OW : XW) + 1;

   localparam logic signed [QW-1:0] NEG_TWO  = QW'(-2);
   localparam logic signed [QW-1:0] BIAS_POS = QW'(2);
   localparam logic signed [QW-1:0] BIAS_NEG = QW'(5);

   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [RADIUS_BITS-1:0]       rx_ff, ry_ff;
   logic [SW-1:0]                rx2_ff, ry2_ff;
   logic [XW-1:0]                x_ff;
   logic [RADIUS_BITS-1:0]       y_ff;
   logic [GW-1:0]                gx_ff, gy_ff;
   logic signed [BW-1:0]         sq_ff, diff_ff;
   logic signed [QW-1:0]         prod_ff, q_ff, dec_ff;

   logic                         pv_ff, fin_ff;
   logic signed [OW-1:0]         east_ff, west_ff, north_ff, south_ff;

   logic [XW:0]                  tx;
   logic signed [YW-1:0]         ym;
   logic signed [AW-1:0]         mul_a;
   logic signed [BW-1:0]         mul_b;
   logic signed [QW-1:0]         prod_in;
   logic signed [QW-1:0]         q_rnd;
   logic [GW-1:0]                two_rx2, two_ry2;
   logic                         dec_neg, dec_pos;
   logic signed [EW-1:0]         cx_e, cy_e, x_e, y_e;
   logic signed [EW-1:0]         east_s, west_s, north_s, south_s;

   // Derived operands
   assign tx      = {x_ff, 1'b1};
   assign ym      = $signed({1'b0, y_ff}) - $signed(YW'(1));
   assign two_rx2 = GW'({rx2_ff, 1'b0});
   assign two_ry2 = GW'({ry2_ff, 1'b0});
   assign dec_neg = dec_ff[QW-1];
   assign dec_pos = !dec_ff[QW-1] && (dec_ff != '0);

   // Status to the controller
   assign status.r1_go  = gx_ff < gy_ff;
   assign status.y_zero = y_ff == '0;

   // Shared multiplier operand selection
   always_comb begin
      unique case (cmd.op)
         OP_MUL_RX: begin
            mul_a = AW'(rx_ff);
            mul_b = BW'(rx_ff);
         end
         OP_MUL_RY: begin
            mul_a = AW'(ry_ff);
            mul_b = BW'(ry_ff);
         end
         OP_MUL_GRAD: begin
            mul_a = AW'(rx2_ff);
            mul_b = BW'(ry_ff);
         end
         OP_MUL_TX: begin
            mul_a = AW'(tx);
            mul_b = BW'(tx);
         end
         OP_MUL_YM: begin
            mul_a = AW'(ym);
            mul_b = BW'(ym);
         end
         OP_MUL_RY2SQ: begin
            mul_a = AW'(ry2_ff);
            mul_b = sq_ff;
         end
         OP_MUL_RX2D: begin
            mul_a = AW'(rx2_ff);
            mul_b = diff_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = QW'(mul_a) * QW'(mul_b);

   // trunc((q + 2) / 4) toward zero
   assign q_rnd = q_ff + ((q_ff < NEG_TWO) ? BIAS_NEG : BIAS_POS);

   // Result coordinates, wrapped to the output width
   assign cx_e    = EW'(cx_ff);
   assign cy_e    = EW'(cy_ff);
   assign x_e     = $signed(EW'(x_ff));
   assign y_e     = $signed(EW'(y_ff));
   assign east_s  = cx_e + x_e;
   assign west_s  = cx_e - x_e;
   assign north_s = cy_e + y_e;
   assign south_s = cy_e - y_e;

   // Working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         OP_NONE, OP_MUL_RX, OP_MUL_TX: begin
         end
         OP_LOAD: begin
            cx_ff <= req_centre_x;
            cy_ff <= req_centre_y;
            rx_ff <= req_radius_x;
            ry_ff <= req_radius_y;
            x_ff  <= '0;
            y_ff  <= req_radius_y;
            gx_ff <= '0;
         end
         OP_MUL_RY: begin
            rx2_ff <= prod_ff[SW-1:0];
         end
         OP_MUL_GRAD: begin
            ry2_ff <= prod_ff[SW-1:0];
         end
         OP_START_Q: begin
            gy_ff <= {prod_ff[GW-2:0], 1'b0};
            q_ff  <= QW'({ry2_ff, 2'b00}) + QW'(rx2_ff) - (prod_ff <<< 2);
         end
         OP_MUL_YM: begin
            sq_ff <= prod_ff[BW-1:0];
         end
         OP_MUL_RY2SQ: begin
            diff_ff <= $signed(prod_ff[BW-1:0]) - $signed(BW'(ry2_ff));
         end
         OP_MUL_RX2D: begin
            q_ff <= prod_ff;
         end
         OP_R2_Q: begin
            q_ff <= q_ff + (prod_ff <<< 2);
         end
         OP_ROUND: begin
            dec_ff <= q_rnd >>> 2;
         end
         OP_STEP_A: begin
            if (!cmd.region_two) begin
               x_ff  <= x_ff + XW'(1);
               gx_ff <= gx_ff + two_ry2;
               if (!dec_neg) begin
                  y_ff  <= y_ff - RADIUS_BITS'(1);
                  gy_ff <= gy_ff - two_rx2;
               end
            end else begin
               y_ff  <= y_ff - RADIUS_BITS'(1);
               gy_ff <= gy_ff - two_rx2;
               if (!dec_pos) begin
                  x_ff  <= x_ff + XW'(1);
                  gx_ff <= gx_ff + two_ry2;
               end
            end
         end
         OP_STEP_B: begin
            // gradients already hold their updated values
            if (!cmd.region_two) begin
               dec_ff <= dec_ff + QW'(ry2_ff) + QW'(gx_ff)
                         - (dec_neg ? QW'(0) : QW'(gy_ff));
            end else begin
               dec_ff <= dec_ff + QW'(rx2_ff) - QW'(gy_ff)
                         + (dec_pos ? QW'(0) : QW'(gx_ff));
            end
         end
      endcase

      // Result register
      if (cmd.out_load) begin
         pv_ff  <= cmd.out_kind == OUT_POINTS;
         fin_ff <= (cmd.out_kind == OUT_NONE) || status.y_zero;
         if (cmd.out_kind == OUT_POINTS) begin
            east_ff  <= east_s[OW-1:0];
            west_ff  <= west_s[OW-1:0];
            north_ff <= north_s[OW-1:0];
            south_ff <= south_s[OW-1:0];
         end else begin
            east_ff  <= '0;
            west_ff  <= '0;
            north_ff <= '0;
            south_ff <= '0;
         end
      end
   end

   assign rsp_points_valid = pv_ff;
   assign rsp_finished     = fin_ff;
   assign rsp_east_x       = east_ff;
   assign rsp_west_x       = west_ff;
   assign rsp_north_y      = north_ff;
   assign rsp_south_y      = south_ff;

endmodule

/* rtl/mer_control.sv */
// Controller: sequences start setup, region switch and step updates.
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_control import mer_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_opcode,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output mer_cmd_type    cmd,
   input  mer_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_GRAD,
      ST_START_Q,
      ST_TX,
      ST_YM,
      ST_RY2SQ,
      ST_RX2D,
      ST_R2Q,
      ST_ROUND,
      ST_STEP_A,
      ST_STEP_B,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_R1,
      PH_R2
   } phase_type;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   out_kind_type kind_ff, kind_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         accept;
   logic         out_load;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OPC_START) begin
                  state_in = ST_SQ_RX;
                  phase_in = PH_R1;
                  kind_in  = OUT_START;
               end else begin
                  priority if (phase_ff == PH_R1 && !status.r1_go) begin
                     state_in = ST_TX;
                     phase_in = PH_R2;
                  end else if (phase_ff == PH_R1 ||
                               (phase_ff == PH_R2 && !status.y_zero)) begin
                     state_in = ST_STEP_A;
                     kind_in  = OUT_POINTS;
                  end else begin
                     state_in = ST_EMIT;
                     kind_in  = OUT_NONE;
                  end
               end
            end
         end
         ST_SQ_RX:   state_in = ST_SQ_RY;
         ST_SQ_RY:   state_in = ST_GRAD;
         ST_GRAD:    state_in = ST_START_Q;
         ST_START_Q: state_in = ST_ROUND;
         ST_TX:      state_in = ST_YM;
         ST_YM:      state_in = ST_RY2SQ;
         ST_RY2SQ:   state_in = ST_RX2D;
         ST_RX2D:    state_in = ST_R2Q;
         ST_R2Q:     state_in = ST_ROUND;
         ST_ROUND: begin
            priority if (phase_ff == PH_R1) begin
               state_in = ST_EMIT;
            end else if (status.y_zero) begin
               state_in = ST_EMIT;
               kind_in  = OUT_NONE;
            end else begin
               state_in = ST_STEP_A;
               kind_in  = OUT_POINTS;
            end
         end
         ST_STEP_A:  state_in = ST_STEP_B;
         ST_STEP_B:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath command
   always_comb begin
      unique case (state_ff)
         ST_IDLE:    cmd.op = (accept && req_opcode == OPC_START) ? OP_LOAD : OP_NONE;
         ST_SQ_RX:   cmd.op = OP_MUL_RX;
         ST_SQ_RY:   cmd.op = OP_MUL_RY;
         ST_GRAD:    cmd.op = OP_MUL_GRAD;
         ST_START_Q: cmd.op = OP_START_Q;
         ST_TX:      cmd.op = OP_MUL_TX;
         ST_YM:      cmd.op = OP_MUL_YM;
         ST_RY2SQ:   cmd.op = OP_MUL_RY2SQ;
         ST_RX2D:    cmd.op = OP_MUL_RX2D;
         ST_R2Q:     cmd.op = OP_R2_Q;
         ST_ROUND:   cmd.op = OP_ROUND;
         ST_STEP_A:  cmd.op = OP_STEP_A;
         ST_STEP_B:  cmd.op = OP_STEP_B;
         default:    cmd.op = OP_NONE;
      endcase
      cmd.region_two = phase_ff == PH_R2;
      cmd.out_kind   = kind_ff;
      cmd.out_load   = out_load;
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         kind_ff      <= OUT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A region-one step only runs while grad_x < grad_y
   `MER_ASSERT_SAME(a_r1_step_go, clock, reset,
                    (state_ff == ST_STEP_A && phase_ff == PH_R1), status.r1_go)
   // A region-two step never runs with offset_y at zero
   `MER_ASSERT_SAME(a_r2_step_y, clock, reset,
                    (state_ff == ST_STEP_A && phase_ff == PH_R2), !status.y_zero)
   // A start beat always opens region one
   `MER_ASSERT_NEXT(a_start_r1, clock, reset,
                    (accept && req_opcode == OPC_START), (phase_ff == PH_R1))
   // The ST_STEP_B update state always leads to a point result
   `MER_ASSERT_NEXT(a_step_emit, clock, reset, (state_ff == ST_STEP_B),
                    (state_ff == ST_EMIT && kind_ff == OUT_POINTS))

endmodule

/* test/tb_top.sv */
// Testbench for the midpoint ellipse rasterizer: directed and randomized ellipse walks checked beat by beat.
`timescale 1ns / 100ps

module tb_top;
   import mer_pkg::*;

   localparam int RADIUS_BITS = 12;
   localparam int COORD_BITS  = 16;
   localparam int RANDOM_CMDS = 1100;
   localparam int DRAIN_CYCLES = 20;
   localparam logic OPC_STEP = ~OPC_START;

   // One request beat as it goes onto the request channel
   typedef struct packed {
      logic                         opcode;
      logic signed [COORD_BITS-1:0] centre_x;
      logic signed [COORD_BITS-1:0] centre_y;
      logic [RADIUS_BITS-1:0]       radius_x;
      logic [RADIUS_BITS-1:0]       radius_y;
   } ellipse_cmd_type;

   // One response beat: a set of four symmetric points or a status-only beat
   typedef struct packed {
      logic                       points_valid;
      logic                       finished;
      logic signed [COORD_BITS:0] east_x;
      logic signed [COORD_BITS:0] west_x;
      logic signed [COORD_BITS:0] north_y;
      logic signed [COORD_BITS:0] south_y;
   } plot_beat_type;

   // Which part of the arc the walk is in: x-stepping part, then y-stepping part
   typedef enum logic [1:0] {
      ARC_IDLE,
      ARC_FLAT,
      ARC_STEEP
   } arc_phase_type;

   logic clock;
   logic reset;

   mer_req_if #(.RADIUS_BITS(RADIUS_BITS), .COORD_BITS(COORD_BITS)) req_chan ();
   mer_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan ();

   midpoint_ellipse_rasterizer #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   ellipse_cmd_type cmd_queue[$];
   plot_beat_type   plot_expected[$];
   ellipse_cmd_type drv_cmd;
   plot_beat_type   got_beat;
   plot_beat_type   want_beat;

   int total_cmds  = 0;
   int beats_taken = 0;
   int mismatches  = 0;
   int send_gap    = 0;
   int send_calm   = 0;
   int hold_left   = 0;
   int hold_calm   = 0;

   // Shadow of the walk state
   arc_phase_type arc_phase = ARC_IDLE;
   longint step_x = 0, step_y = 0;
   longint slope_x = 0, slope_y = 0;
   longint err_term = 0;
   longint a_sq = 0, b_sq = 0;
   longint org_x = 0, org_y = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset, once at the start
   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit
   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Decision start values are built in quarter units, then rounded as trunc((q + 2) / 4) toward zero
   function automatic longint quarter_round(input longint q);
      longint n;
      n = q + 2;
      return n / 4;
   endfunction

   // Mostly short delays, a few long ones, and now and then a stretch of none
   function automatic int pick_delay(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Advance the shadow walk by one request beat and give the response it must cause
   function automatic plot_beat_type rasterize_beat(input ellipse_cmd_type c);
      plot_beat_type b;
      longint        tx;
      longint        ym;
      logic          emit;
      b    = '0;
      emit = 1'b0;
      if (c.opcode == OPC_START) begin
         org_x    = longint'($signed(c.centre_x));
         org_y    = longint'($signed(c.centre_y));
         a_sq     = longint'(c.radius_x) * longint'(c.radius_x);
         b_sq     = longint'(c.radius_y) * longint'(c.radius_y);
         step_x   = 0;
         step_y   = longint'(c.radius_y);
         slope_x  = 0;
         slope_y  = 2 * a_sq * step_y;
         err_term = quarter_round(4 * b_sq - 4 * a_sq * step_y + a_sq);
         arc_phase = ARC_FLAT;
         b.finished = (c.radius_y == '0);
         return b;
      end

      // Slope has reached -1: recompute the decision value for the steep part
      if (arc_phase == ARC_FLAT && slope_x >= slope_y) begin
         tx = 2 * step_x + 1;
         ym = step_y - 1;
         err_term = quarter_round(b_sq * tx * tx + 4 * a_sq * ym * ym - 4 * a_sq * b_sq);
         arc_phase = ARC_STEEP;
      end

      if (arc_phase == ARC_FLAT) begin
         step_x++;
         slope_x += 2 * b_sq;
         if (err_term < 0) begin
            err_term += b_sq + slope_x;
         end else begin
            step_y--;
            slope_y -= 2 * a_sq;
            err_term += b_sq + slope_x - slope_y;
         end
         emit = 1'b1;
      end else if (arc_phase == ARC_STEEP && step_y > 0) begin
         step_y--;
         slope_y -= 2 * a_sq;
         if (err_term > 0) begin
            err_term += a_sq - slope_y;
         end else begin
            step_x++;
            slope_x += 2 * b_sq;
            err_term += a_sq - slope_y + slope_x;
         end
         emit = 1'b1;
      end

      if (!emit) begin
         b.finished = 1'b1;
      end else begin
         b.points_valid = 1'b1;
         b.finished     = (step_y <= 0);
         b.east_x       = 17'(org_x + step_x);
         b.west_x       = 17'(org_x - step_x);
         b.north_y      = 17'(org_y + step_y);
         b.south_y      = 17'(org_y - step_y);
      end
      return b;
   endfunction

   task automatic add_cmd(input logic op, input logic [COORD_BITS-1:0] cx,
                          input logic [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] rx,
                          input logic [RADIUS_BITS-1:0] ry);
      ellipse_cmd_type c;
      c.opcode   = op;
      c.centre_x = cx;
      c.centre_y = cy;
      c.radius_x = rx;
      c.radius_y = ry;
      cmd_queue.push_back(c);
   endtask

   // Step beats carry random content in the fields the block ignores
   task automatic add_step();
      add_cmd(OPC_STEP, 16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom));
   endtask

   task automatic add_ellipse(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                              input int rx, input int ry, input int n_steps);
      add_cmd(OPC_START, cx, cy, 12'(rx), 12'(ry));
      repeat (n_steps) add_step();
   endtask

   // Stimulus and end of test
   initial begin
      int pick;
      int rx;
      int ry;
      int n_steps;
      int target;
      req_chan.valid    = 1'b0;
      req_chan.opcode   = OPC_STEP;
      req_chan.centre_x = '0;
      req_chan.centre_y = '0;
      req_chan.radius_x = '0;
      req_chan.radius_y = '0;
      rsp_chan.ready    = 1'b0;

      // Step before any start: nothing to draw
      add_step();
      // Extreme centres, small ellipse run to its end and past it
      add_ellipse(16'h7fff, 16'h8000, 3, 2, 7);
      // Zero horizontal radius: flat part skipped, walk down at x 0
      add_ellipse(16'h8000, 16'h7fff, 0, 3, 5);
      // Zero vertical radius: finished right at the start
      add_ellipse(16'h0000, 16'h0000, 5, 0, 2);
      add_ellipse(16'hffff, 16'h0001, 0, 0, 1);
      // Largest radii, a partial walk cut short by a new start
      add_ellipse(16'h8000, 16'h8000, 4095, 4095, 3);
      add_ellipse(16'h7fff, 16'h7fff, 4095, 1, 2);

      // Random ellipses: mostly small and walked to the end, some aborted, a few huge
      target = cmd_queue.size() + RANDOM_CMDS;
      while (cmd_queue.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            rx      = $urandom_range(0, 4095);
            ry      = $urandom_range(0, 4095);
            n_steps = $urandom_range(1, 30);
         end else if (pick < 5) begin
            rx      = $urandom_range(0, 8);
            ry      = $urandom_range(2000, 4095);
            n_steps = $urandom_range(10, 40);
         end else begin
            rx = $urandom_range(0, 40);
            ry = $urandom_range(0, 40);
            if ($urandom_range(0, 9) < 7) n_steps = rx + ry + $urandom_range(2, 4);
            else n_steps = $urandom_range(0, rx + ry);
         end
         add_ellipse(16'($urandom), 16'($urandom), rx, ry, n_steps);
      end
      total_cmds = cmd_queue.size();

      while (beats_taken < total_cmds) @(posedge clock);
      while (plot_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Request driver: predict on each accepted beat, then present the next one after a gap
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            plot_expected.push_back(rasterize_beat(drv_cmd));
            beats_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               drv_cmd = cmd_queue.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.opcode   <= drv_cmd.opcode;
               req_chan.centre_x <= drv_cmd.centre_x;
               req_chan.centre_y <= drv_cmd.centre_y;
               req_chan.radius_x <= drv_cmd.radius_x;
               req_chan.radius_y <= drv_cmd.radius_y;
               send_gap = pick_delay(send_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each accepted beat with the oldest prediction, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_beat.points_valid = rsp_chan.points_valid;
            got_beat.finished     = rsp_chan.finished;
            got_beat.east_x       = rsp_chan.east_x;
            got_beat.west_x       = rsp_chan.west_x;
            got_beat.north_y      = rsp_chan.north_y;
            got_beat.south_y      = rsp_chan.south_y;
            if (plot_expected.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response beat with none expected: pv=%b fin=%b", $realtime,
                           got_beat.points_valid, got_beat.finished);
               mismatches++;
            end else begin
               want_beat = plot_expected.pop_front();
               if (got_beat.points_valid !== want_beat.points_valid ||
                   got_beat.finished !== want_beat.finished ||
                   got_beat.east_x !== want_beat.east_x ||
                   got_beat.west_x !== want_beat.west_x ||
                   got_beat.north_y !== want_beat.north_y ||
                   got_beat.south_y !== want_beat.south_y) begin
                  if (mismatches < 10) begin
                     $display("%0t: mismatch exp pv=%b fin=%b e=%0d w=%0d n=%0d s=%0d",
                              $realtime, want_beat.points_valid, want_beat.finished,
                              want_beat.east_x, want_beat.west_x, want_beat.north_y,
                              want_beat.south_y);
                     $display("%0t:          got pv=%b fin=%b e=%0d w=%0d n=%0d s=%0d",
                              $realtime, got_beat.points_valid, got_beat.finished,
                              got_beat.east_x, got_beat.west_x, got_beat.north_y,
                              got_beat.south_y);
                  end
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            hold_left = pick_delay(hold_calm);
         end
      end
   end

endmodule

/* files.f */
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_if.sv
rtl/mer_datapath.sv
rtl/mer_control.sv
rtl/midpoint_ellipse_rasterizer.sv
test/tb_top.sv
